// ===== rtl/core/fmfb_pkg.sv =====
// Shared constants, types and a helper function for the two-modulator feedback FM oscillator.
package fmfb_pkg;

   localparam int SINE_ADDR_BITS = 10;
   localparam int PHASE_BITS     = 32;
   localparam int QUAD_BITS      = SINE_ADDR_BITS - 2;

   localparam logic [31:0] PHASE_MASK = 32'hFFFF_FFFF << (32 - PHASE_BITS);
   localparam logic [31:0] HALF_TURN  = 32'h8000_0000;

   // Quarter-wave polynomial coefficients.
   localparam logic [16:0] SIN_A = 17'd51472;
   localparam logic [16:0] SIN_B = 17'd21315;
   localparam logic [16:0] SIN_C = 17'd2611;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 22;
   localparam int MUL_B_W = 18;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CARRIER_STEP   = 3'd0,
      CSR_MOD1_STEP      = 3'd1,
      CSR_MOD2_STEP      = 3'd2,
      CSR_DEPTH_ONE      = 3'd3,
      CSR_DEPTH_TWO      = 3'd4,
      CSR_FEEDBACK_DEPTH = 3'd5,
      CSR_PHASE_OFFSET   = 3'd6,
      CSR_AVERAGE_MODE   = 3'd7
   } csr_index_type;

   // Steps above half a turn are held at half a turn.
   function automatic logic [31:0] clamp_step(input logic [31:0] step);
      logic [31:0] limited;
      limited = (step > HALF_TURN) ? HALF_TURN : step;
      return limited & PHASE_MASK;
   endfunction

endpackage

// ===== rtl/core/fmfb_chan_if.sv =====
// Valid/ready channel interfaces for the oscillator request and response beats.
interface fmfb_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic signed [15:0] fm_sample;
   logic [20:0] fm_depth;

   modport source (output valid, output restart, output fm_sample, output fm_depth,
                   input ready);
   modport sink (input valid, input restart, input fm_sample, input fm_depth,
                 output ready);
endinterface

interface fmfb_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [15:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

// ===== rtl/core/fmfb_mul.sv =====
// Shared signed multiplier with a registered product.
module fmfb_mul import fmfb_pkg::*; (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [MUL_A_W-1:0] op_a,
   input  logic signed [MUL_B_W-1:0] op_b,
   output logic signed [MUL_P_W-1:0] product
);

   logic signed [MUL_P_W-1:0] product_ff;
   logic signed [MUL_P_W-1:0] product_in;

   assign product_in = MUL_P_W'(op_a) * MUL_P_W'(op_b);

   always_ff @(posedge clock) begin
      if (en) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

// ===== rtl/core/fm_two_modulator_feedback_osc.sv =====
// Two-modulator FM oscillator with output feedback, built round one shared multiplier.
// A normal beat forms the sine of each modulator, the feedback product (plus a squaring step
// with squared feedback), the FM product and the output sine; ready rises at the edge that
// fills the result register, so a new beat is taken only when the last is done. A restart
// beat gives no result and frees the input once it has set the carrier phase from its sine.
// Reset is synchronous: phases, history, output and configuration registers clear to zero and the block is idle.
module fm_two_modulator_feedback_osc import fmfb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   fmfb_req_if.sink               req,
   fmfb_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_Z2,
      ST_T1,
      ST_T2,
      ST_R,
      ST_FIN,
      ST_ADD,
      ST_FB_SQ,
      ST_FB_ADD,
      ST_FM_ADD
   } state_type;

   typedef enum logic [1:0] {
      JOB_MOD1,
      JOB_MOD2,
      JOB_OUT,
      JOB_RST
   } job_type;

   // Configuration registers.
   logic [31:0]        carrier_step_ff;
   logic [31:0]        mod1_step_ff;
   logic [31:0]        mod2_step_ff;
   logic [18:0]        depth_one_ff;
   logic [18:0]        depth_two_ff;
   logic signed [17:0] feedback_depth_ff;
   logic [15:0]        phase_offset_ff;
   logic               average_mode_ff;

   // Sequencer and datapath state.
   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [31:0]        acc_ff, acc_in;
   logic [31:0]        sin_arg_ff, sin_arg_in;
   logic [16:0]        z2_ff, z2_in;
   logic [31:0]        carrier_ff, carrier_in;
   logic [31:0]        mod1_ff, mod1_in;
   logic [31:0]        mod2_ff, mod2_in;
   logic signed [15:0] last_ff, last_in;
   logic signed [15:0] earlier_ff, earlier_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_sample_ff, rsp_sample_in;
   logic signed [15:0] fm_sample_ff;
   logic [20:0]        fm_depth_ff;

   // Combinational helpers.
   logic                      req_accept;
   logic [SINE_ADDR_BITS-1:0] sine_addr;
   logic [1:0]                quad;
   logic [QUAD_BITS-1:0]      idx;
   logic [16:0]               z_raw;
   logic [16:0]               z;
   logic [16:0]               pz;
   logic [14:0]               r15;
   logic signed [15:0]        r_ext;
   logic signed [15:0]        sine_val;
   logic [31:0]               scaled;
   logic [31:0]               off_ph;
   logic [31:0]               mod1_next;
   logic signed [16:0]        fb_value;
   logic [17:0]               fb_mag;
   logic [20:0]               depth_sel;
   logic                      out_stall;
   logic                      mul_en;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;

   fmfb_mul u_mul (
      .clock   (clock),
      .en      (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   assign req.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && (state_ff == ST_IDLE);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.sample = rsp_sample_ff;

   // Sine argument decode: quadrant and position within the quadrant in Q15.
   assign sine_addr = sin_arg_ff[31 -: SINE_ADDR_BITS];
   assign quad      = sine_addr[SINE_ADDR_BITS-1 -: 2];
   assign idx       = sine_addr[QUAD_BITS-1:0];
   assign z_raw     = 17'(idx) << (15 - QUAD_BITS);
   assign z         = quad[0] ? (17'd32768 - z_raw) : z_raw;

   assign pz       = prod[31:15];
   assign r15      = (pz > 17'd32767) ? 15'h7FFF : pz[14:0];
   assign r_ext    = $signed({1'b0, r15});
   assign sine_val = quad[1] ? -r_ext : r_ext;

   assign scaled    = {prod[30:0], 1'b0};
   assign off_ph    = {phase_offset_ff, 16'h0000} & PHASE_MASK;
   assign mod1_next = (mod1_ff + clamp_step(mod1_step_ff)) & PHASE_MASK;

   assign fb_value = average_mode_ff ? (17'(last_ff) + 17'(earlier_ff))
                                     : $signed({last_ff, 1'b0});
   assign fb_mag   = feedback_depth_ff[17] ? 18'(-feedback_depth_ff)
                                           : 18'(feedback_depth_ff);

   always_comb begin
      unique case (job_ff)
         JOB_MOD1: depth_sel = 21'(depth_one_ff);
         JOB_MOD2: depth_sel = 21'(depth_two_ff);
         JOB_RST:  depth_sel = 21'(depth_one_ff) + 21'(depth_two_ff);
         JOB_OUT:  depth_sel = 21'd0;
      endcase
   end

   // A finished sample waits in the final step while the response register is still full.
   assign out_stall = (state_ff == ST_FIN) && (job_ff == JOB_OUT) && rsp_valid_ff && !rsp.ready;
   assign mul_en    = !out_stall;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_Z2: begin
            mul_a = MUL_A_W'(z);
            mul_b = MUL_B_W'(z);
         end
         ST_T1: begin
            mul_a = MUL_A_W'(SIN_C);
            mul_b = MUL_B_W'(pz);
         end
         ST_T2: begin
            mul_a = MUL_A_W'(z2_ff);
            mul_b = MUL_B_W'(SIN_B - pz);
         end
         ST_R: begin
            mul_a = MUL_A_W'(SIN_A - pz);
            mul_b = MUL_B_W'(z);
         end
         ST_FIN: begin
            mul_a = MUL_A_W'(depth_sel);
            mul_b = MUL_B_W'(sine_val);
         end
         ST_ADD: begin
            if (feedback_depth_ff[17]) begin
               mul_a = MUL_A_W'(fb_value);
               mul_b = MUL_B_W'(fb_value);
            end else begin
               mul_a = MUL_A_W'(fb_mag);
               mul_b = MUL_B_W'(fb_value);
            end
         end
         ST_FB_SQ: begin
            mul_a = MUL_A_W'(fb_mag);
            mul_b = MUL_B_W'(prod[33:16]);
         end
         ST_FB_ADD: begin
            mul_a = MUL_A_W'(fm_depth_ff);
            mul_b = MUL_B_W'(fm_sample_ff);
         end
         ST_IDLE, ST_FM_ADD: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer next-state and datapath updates.
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      acc_in        = acc_ff;
      sin_arg_in    = sin_arg_ff;
      z2_in         = z2_ff;
      carrier_in    = carrier_ff;
      mod1_in       = mod1_ff;
      mod2_in       = mod2_ff;
      last_in       = last_ff;
      earlier_in    = earlier_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_Z2;
               if (req.restart) begin
                  mod1_in    = off_ph;
                  mod2_in    = off_ph;
                  last_in    = '0;
                  earlier_in = '0;
                  sin_arg_in = off_ph;
                  job_in     = JOB_RST;
               end else begin
                  mod1_in    = mod1_next;
                  mod2_in    = (mod2_ff + clamp_step(mod2_step_ff)) & PHASE_MASK;
                  sin_arg_in = mod1_next;
                  acc_in     = carrier_ff + {phase_offset_ff, 16'h0000};
                  job_in     = JOB_MOD1;
               end
            end
         end
         ST_Z2: state_in = ST_T1;
         ST_T1: begin
            z2_in    = pz;
            state_in = ST_T2;
         end
         ST_T2: state_in = ST_R;
         ST_R:  state_in = ST_FIN;
         ST_FIN: begin
            if (job_ff == JOB_OUT) begin
               if (!out_stall) begin
                  rsp_valid_in  = 1'b1;
                  rsp_sample_in = sine_val;
                  earlier_in    = last_ff;
                  last_in       = sine_val;
                  carrier_in    = (carrier_ff + clamp_step(carrier_step_ff)) & PHASE_MASK;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            unique case (job_ff)
               JOB_MOD1: begin
                  acc_in     = acc_ff + scaled;
                  sin_arg_in = mod2_ff;
                  job_in     = JOB_MOD2;
                  state_in   = ST_Z2;
               end
               JOB_MOD2: begin
                  acc_in   = acc_ff + scaled;
                  state_in = feedback_depth_ff[17] ? ST_FB_SQ : ST_FB_ADD;
               end
               JOB_RST: begin
                  carrier_in = (32'd0 - scaled - off_ph) & PHASE_MASK;
                  state_in   = ST_IDLE;
               end
               JOB_OUT: state_in = ST_IDLE;
            endcase
         end
         ST_FB_SQ: state_in = ST_FB_ADD;
         ST_FB_ADD: begin
            acc_in   = acc_ff + prod[31:0];
            state_in = ST_FM_ADD;
         end
         ST_FM_ADD: begin
            sin_arg_in = (acc_ff + scaled) & PHASE_MASK;
            job_in     = JOB_OUT;
            state_in   = ST_Z2;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         job_ff        <= JOB_MOD1;
         carrier_ff    <= '0;
         mod1_ff       <= '0;
         mod2_ff       <= '0;
         last_ff       <= '0;
         earlier_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_sample_ff <= '0;
      end else begin
         state_ff      <= state_in;
         job_ff        <= job_in;
         carrier_ff    <= carrier_in;
         mod1_ff       <= mod1_in;
         mod2_ff       <= mod2_in;
         last_ff       <= last_in;
         earlier_ff    <= earlier_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      sin_arg_ff    <= sin_arg_in;
      z2_ff         <= z2_in;
      if (req_accept) begin
         fm_sample_ff <= req.fm_sample;
         fm_depth_ff  <= req.fm_depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carrier_step_ff   <= '0;
         mod1_step_ff      <= '0;
         mod2_step_ff      <= '0;
         depth_one_ff      <= '0;
         depth_two_ff      <= '0;
         feedback_depth_ff <= '0;
         phase_offset_ff   <= '0;
         average_mode_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CARRIER_STEP:   carrier_step_ff   <= csr_wdata;
            CSR_MOD1_STEP:      mod1_step_ff      <= csr_wdata;
            CSR_MOD2_STEP:      mod2_step_ff      <= csr_wdata;
            CSR_DEPTH_ONE:      depth_one_ff      <= csr_wdata[18:0];
            CSR_DEPTH_TWO:      depth_two_ff      <= csr_wdata[18:0];
            CSR_FEEDBACK_DEPTH: feedback_depth_ff <= $signed(csr_wdata[17:0]);
            CSR_PHASE_OFFSET:   phase_offset_ff   <= csr_wdata[15:0];
            CSR_AVERAGE_MODE:   average_mode_ff   <= csr_wdata[0];
         endcase
      end
   end

endmodule
